>>> sv/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define CHK_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> sv/bxds_pkg.sv
// ----------------------------------------------------------------------------
// bxds_pkg
// shared constants, types and helpers of the box average downscaler
// ----------------------------------------------------------------------------
package bxds_pkg;

	localparam int unsigned MAX_SRC_WIDTH  = 4096;
	localparam int unsigned MAX_SRC_HEIGHT = 4096;
	localparam int unsigned MAX_DST_WIDTH  = 256;
	localparam int unsigned MAX_DST_HEIGHT = 256;

	localparam int unsigned CFG_W   = 13;
	localparam int unsigned SIZE_W  = 13;
	localparam int unsigned DSIZE_W = 9;
	localparam int unsigned POS_W   = 12;
	localparam int unsigned OPOS_W  = 8;
	localparam int unsigned SUM_W   = 32;
	localparam int unsigned CNT_W   = 25;
	localparam int unsigned QUO_W   = 8;
	localparam int unsigned REM_W   = SUM_W + 2;

	typedef enum logic [1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_DST_WIDTH  = 2'd2,
		REG_DST_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [SUM_W-1:0] red;
		logic [SUM_W-1:0] green;
		logic [SUM_W-1:0] blue;
		logic [CNT_W-1:0] count;
	} line_word_t;

	// clamp a source size to 1..max
	function automatic logic [SIZE_W-1:0] clamp_src(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] max_v);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > max_v) begin
			r = max_v;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// clamp a destination size to 1..max and to the source size
	function automatic logic [DSIZE_W-1:0] clamp_dst(input logic [DSIZE_W-1:0] v,
			input logic [DSIZE_W-1:0] max_v, input logic [SIZE_W-1:0] src);
		logic [DSIZE_W-1:0] r;
		if (v == '0) begin
			r = DSIZE_W'(1);
		end else if (v > max_v) begin
			r = max_v;
		end else begin
			r = v;
		end
		if ({{(SIZE_W-DSIZE_W){1'b0}}, r} > src) begin
			r = src[DSIZE_W-1:0];
		end
		return r;
	endfunction

	// step the box boundary remainder by one source index
	function automatic logic [SIZE_W-1:0] rem_step(input logic [SIZE_W-1:0] rem,
			input logic [DSIZE_W-1:0] d, input logic [SIZE_W-1:0] s);
		logic [SIZE_W:0] diff;
		diff = {1'b0, rem} - {{(SIZE_W+1-DSIZE_W){1'b0}}, d};
		if (diff[SIZE_W]) begin
			return diff[SIZE_W-1:0] + s;
		end
		return diff[SIZE_W-1:0];
	endfunction

endpackage

>>> sv/box_average_downscaler_core.sv
// ----------------------------------------------------------------------------
// box_average_downscaler_core
// area-average downscaler with a per-column line store of channel sums
// ----------------------------------------------------------------------------
// source pixels enter in raster order on in_valid/in_ready, one word each.
// averaged pixels leave on out_valid/out_ready with their output column, row
// and a frame_done flag on the last pixel of the frame; alpha is always 255.
// sizes are set through cfg_we/cfg_addr/cfg_wdata; the user must write them
// only while the block is idle, which the block does not enforce. any write
// restarts the frame and holds in_ready low in the cycle after the write.
// each source pixel is a read of the line store entry of its output column,
// then the summed write-back. a pixel that closes a box goes on to the
// rounded divide (one quotient bit per cycle, 8 bits) and then to a load of
// the output register; no new pixel is taken until then. the output
// register lets the next pixel be accepted while a result waits; a divide
// that finishes while the previous result is unread waits for out_ready first.
// reset returns all sizes to 1 and the position counters to the first box;
// line store contents need no clearing since every box starts by overwriting.
// ----------------------------------------------------------------------------
module box_average_downscaler_core
	import bxds_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           red_in,
	input  logic [7:0]           green_in,
	input  logic [7:0]           blue_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           red_out,
	output logic [7:0]           green_out,
	output logic [7:0]           blue_out,
	output logic [7:0]           alpha_out,
	output logic [OPOS_W-1:0]    out_column,
	output logic [OPOS_W-1:0]    out_row,
	output logic                 frame_done
);

	`include "assert_macros.svh"

	typedef enum logic [1:0] {ST_IDLE, ST_RMW, ST_DIV, ST_FIN} state_t;

	state_t state_q;

	logic [SIZE_W-1:0]  src_w_q, src_h_q;
	logic [DSIZE_W-1:0] dst_w_q, dst_h_q;
	logic               restart_q;

	logic [SIZE_W-1:0]  sw_e, sh_e;
	logic [DSIZE_W-1:0] dw_e, dh_e;

	logic [POS_W-1:0]   col_q, row_q;
	logic [OPOS_W-1:0]  ocol_q, orow_q;
	logic [SIZE_W-1:0]  rem_col_q, rem_row_q;
	logic               first_col_q, first_row_q;

	logic               accept;
	logic               last_col, last_row, col_end, row_end;

	// item registers between read and write-back
	logic [7:0]         red_s1, green_s1, blue_s1;
	logic               first_s1, emit_s1, done_s1;
	logic [OPOS_W-1:0]  ocol_s1, orow_s1;

	line_word_t         line_mem [MAX_DST_WIDTH];
	line_word_t         rd_word_s1;
	line_word_t         wr_word;

	// divider
	logic [REM_W-1:0]   num_q [3];
	logic [REM_W-1:0]   den_q;
	logic [QUO_W-1:0]   quo_q [3];
	logic [2:0]         step_q;
	logic               zero_q;
	logic               done_s2;
	logic [OPOS_W-1:0]  ocol_s2, orow_s2;
	logic               out_free;

	assign sw_e = clamp_src(src_w_q, SIZE_W'(MAX_SRC_WIDTH));
	assign sh_e = clamp_src(src_h_q, SIZE_W'(MAX_SRC_HEIGHT));
	assign dw_e = clamp_dst(dst_w_q, DSIZE_W'(MAX_DST_WIDTH), sw_e);
	assign dh_e = clamp_dst(dst_h_q, DSIZE_W'(MAX_DST_HEIGHT), sh_e);

	assign in_ready = (state_q == ST_IDLE) && !restart_q;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	// a box closes where the next source index would start a new box
	assign last_col = {{(SIZE_W-DSIZE_W){1'b0}}, dw_e} > rem_col_q;
	assign last_row = {{(SIZE_W-DSIZE_W){1'b0}}, dh_e} > rem_row_q;
	assign col_end  = ({1'b0, col_q} + SIZE_W'(1)) >= sw_e;
	assign row_end  = ({1'b0, row_q} + SIZE_W'(1)) >= sh_e;

	assign alpha_out = 8'hFF;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q   <= SIZE_W'(1);
			src_h_q   <= SIZE_W'(1);
			dst_w_q   <= DSIZE_W'(1);
			dst_h_q   <= DSIZE_W'(1);
			restart_q <= 1'b0;
		end else begin
			restart_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_addr))
					REG_SRC_WIDTH:  src_w_q <= cfg_wdata;
					REG_SRC_HEIGHT: src_h_q <= cfg_wdata;
					REG_DST_WIDTH:  dst_w_q <= cfg_wdata[DSIZE_W-1:0];
					REG_DST_HEIGHT: dst_h_q <= cfg_wdata[DSIZE_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// position counters and box tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			ocol_q      <= '0;
			orow_q      <= '0;
			rem_col_q   <= '0;
			rem_row_q   <= '0;
			first_col_q <= 1'b1;
			first_row_q <= 1'b1;
		end else if (restart_q) begin
			col_q       <= '0;
			row_q       <= '0;
			ocol_q      <= '0;
			orow_q      <= '0;
			rem_col_q   <= sw_e - {{(SIZE_W-DSIZE_W){1'b0}}, dw_e};
			rem_row_q   <= sh_e - {{(SIZE_W-DSIZE_W){1'b0}}, dh_e};
			first_col_q <= 1'b1;
			first_row_q <= 1'b1;
		end else if (accept) begin
			if (col_end) begin
				col_q       <= '0;
				ocol_q      <= '0;
				rem_col_q   <= sw_e - {{(SIZE_W-DSIZE_W){1'b0}}, dw_e};
				first_col_q <= 1'b1;
				if (row_end) begin
					row_q       <= '0;
					orow_q      <= '0;
					rem_row_q   <= sh_e - {{(SIZE_W-DSIZE_W){1'b0}}, dh_e};
					first_row_q <= 1'b1;
				end else begin
					row_q       <= row_q + POS_W'(1);
					orow_q      <= orow_q + OPOS_W'(last_row);
					rem_row_q   <= rem_step(rem_row_q, dh_e, sh_e);
					first_row_q <= last_row;
				end
			end else begin
				col_q       <= col_q + POS_W'(1);
				ocol_q      <= ocol_q + OPOS_W'(last_col);
				rem_col_q   <= rem_step(rem_col_q, dw_e, sw_e);
				first_col_q <= last_col;
			end
		end
	end

	// line store: read on accept, write back in the following cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_word_s1 <= line_mem[ocol_q];
		end
		if (state_q == ST_RMW) begin
			line_mem[ocol_s1] <= wr_word;
		end
	end

	always_comb begin
		if (first_s1) begin
			wr_word.red   = {{(SUM_W-8){1'b0}}, red_s1};
			wr_word.green = {{(SUM_W-8){1'b0}}, green_s1};
			wr_word.blue  = {{(SUM_W-8){1'b0}}, blue_s1};
			wr_word.count = CNT_W'(1);
		end else begin
			wr_word.red   = rd_word_s1.red + {{(SUM_W-8){1'b0}}, red_s1};
			wr_word.green = rd_word_s1.green + {{(SUM_W-8){1'b0}}, green_s1};
			wr_word.blue  = rd_word_s1.blue + {{(SUM_W-8){1'b0}}, blue_s1};
			wr_word.count = rd_word_s1.count + CNT_W'(1);
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1   <= red_in;
			green_s1 <= green_in;
			blue_s1  <= blue_in;
			first_s1 <= first_col_q && first_row_q;
			emit_s1  <= last_col && last_row;
			ocol_s1  <= ocol_q;
			orow_s1  <= orow_q;
			done_s1  <= (({1'b0, ocol_q} + DSIZE_W'(1)) == dw_e) &&
				(({1'b0, orow_q} + DSIZE_W'(1)) == dh_e);
		end
	end

	// divider: (2*sum + n) / (2*n), one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_RMW && emit_s1) begin
			num_q[0] <= {1'b0, wr_word.red, 1'b0} + REM_W'(wr_word.count);
			num_q[1] <= {1'b0, wr_word.green, 1'b0} + REM_W'(wr_word.count);
			num_q[2] <= {1'b0, wr_word.blue, 1'b0} + REM_W'(wr_word.count);
			den_q    <= {1'b0, wr_word.count, 1'b0, 7'b0};
			zero_q   <= wr_word.count == '0;
			ocol_s2  <= ocol_s1;
			orow_s2  <= orow_s1;
			done_s2  <= done_s1;
		end else if (state_q == ST_DIV) begin
			for (int i = 0; i < 3; i++) begin
				if (num_q[i] >= den_q) begin
					num_q[i] <= num_q[i] - den_q;
					quo_q[i] <= {quo_q[i][QUO_W-2:0], 1'b1};
				end else begin
					quo_q[i] <= {quo_q[i][QUO_W-2:0], 1'b0};
				end
			end
			den_q <= den_q >> 1;
		end
	end

	// control and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RMW;
					end
				end
				ST_RMW: begin
					step_q  <= '0;
					state_q <= emit_s1 ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			red_out    <= zero_q ? '0 : quo_q[0];
			green_out  <= zero_q ? '0 : quo_q[1];
			blue_out   <= zero_q ? '0 : quo_q[2];
			out_column <= ocol_s2;
			out_row    <= orow_s2;
			frame_done <= done_s2;
		end
	end

	`CHK_NEXT(a_accept_to_rmw, accept, state_q == ST_RMW)
	`CHK_ALWAYS(a_rem_col_range, rem_col_q < sw_e || restart_q)
	`CHK_ALWAYS(a_ocol_range, {1'b0, ocol_q} < dw_e || restart_q)
	`CHK_NEXT(a_fin_loads, state_q == ST_FIN && out_free, out_valid)

endmodule

>>> tb/box_average_downscaler_core_tb.sv
// ----------------------------------------------------------------------------
// box_average_downscaler_core_tb
// feeds source pixels under many frame sizes and compares the averaged output
// with an area-average predictor, while both handshakes idle at random
// ----------------------------------------------------------------------------
module box_average_downscaler_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bxds_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 30;
	localparam int TARGET_PIXELS  = 1300;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] col;
		logic [7:0] row;
		logic       done;
	} avg_pixel_t;

	class box_scoreboard;
		int unsigned src_w, src_h, dst_w, dst_h;
		bit [31:0] red_acc [MAX_DST_WIDTH];
		bit [31:0] green_acc [MAX_DST_WIDTH];
		bit [31:0] blue_acc [MAX_DST_WIDTH];
		bit [24:0] pix_cnt [MAX_DST_WIDTH];
		int unsigned scol, srow, ocol, orow, band_end, box_end;
		avg_pixel_t pending[$];
		int errors;

		function void init();
			src_w = 1; src_h = 1; dst_w = 1; dst_h = 1;
			errors = 0;
			restart();
		endfunction

		function int unsigned lim(int unsigned v, int unsigned lo, int unsigned hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		function int unsigned sw();
			return lim(src_w, 1, MAX_SRC_WIDTH);
		endfunction
		function int unsigned sh();
			return lim(src_h, 1, MAX_SRC_HEIGHT);
		endfunction
		function int unsigned dw();
			int unsigned v;
			v = lim(dst_w, 1, MAX_DST_WIDTH);
			return (v > sw()) ? sw() : v;
		endfunction
		function int unsigned dh();
			int unsigned v;
			v = lim(dst_h, 1, MAX_DST_HEIGHT);
			return (v > sh()) ? sh() : v;
		endfunction

		function int unsigned first_idx(int unsigned k, int unsigned s, int unsigned d);
			longint unsigned p;
			p = longint'(k) * s;
			return 32'(p / d);
		endfunction
		function int unsigned last_idx(int unsigned k, int unsigned s, int unsigned d);
			longint unsigned p;
			p = (longint'(k) + 1) * s;
			return 32'((p / d) - 1);
		endfunction

		function void restart();
			scol = 0; srow = 0; ocol = 0; orow = 0;
			box_end = last_idx(0, sw(), dw());
			band_end = last_idx(0, sh(), dh());
		endfunction

		function void set_reg(cfg_reg_t idx, int unsigned v);
			case (idx)
				REG_SRC_WIDTH:  src_w = v & 13'h1fff;
				REG_SRC_HEIGHT: src_h = v & 13'h1fff;
				REG_DST_WIDTH:  dst_w = v & 9'h1ff;
				REG_DST_HEIGHT: dst_h = v & 9'h1ff;
				default: ;
			endcase
			restart();
		endfunction

		function logic [7:0] avg(bit [31:0] s, bit [24:0] n);
			longint unsigned q;
			if (n == 0) return 8'd0;
			q = (longint'(s) * 2 + n) / (longint'(n) * 2);
			return q[7:0];
		endfunction

		function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			int unsigned x;
			bit at_col_end, at_row_end;
			avg_pixel_t e;
			x = ocol;
			if (srow == first_idx(orow, sh(), dh()) && scol == first_idx(ocol, sw(), dw()))
			begin
				red_acc[x] = r; green_acc[x] = g; blue_acc[x] = b; pix_cnt[x] = 1;
			end else begin
				red_acc[x] += r; green_acc[x] += g; blue_acc[x] += b;
				pix_cnt[x] += 1;
			end
			at_col_end = (scol == box_end);
			at_row_end = (srow == band_end);
			if (at_col_end && at_row_end) begin
				e.red   = avg(red_acc[x], pix_cnt[x]);
				e.green = avg(green_acc[x], pix_cnt[x]);
				e.blue  = avg(blue_acc[x], pix_cnt[x]);
				e.alpha = 8'd255;
				e.col   = ocol[7:0];
				e.row   = orow[7:0];
				e.done  = (ocol + 1 == dw()) && (orow + 1 == dh());
				pending = {pending, e};
			end
			if (scol + 1 >= sw()) begin
				scol = 0;
				ocol = 0;
				if (srow + 1 >= sh()) begin
					srow = 0;
					orow = 0;
				end else begin
					srow++;
					if (at_row_end) orow++;
				end
				band_end = last_idx(orow, sh(), dh());
			end else begin
				scol++;
				if (at_col_end) ocol++;
			end
			box_end = last_idx(ocol, sw(), dw());
		endfunction

		function void check_pixel(avg_pixel_t got);
			avg_pixel_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected output word col %0d row %0d",
					got.col, got.row);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: exp rgba %0d %0d %0d %0d c%0d r%0d d%0d,",
						" got %0d %0d %0d %0d c%0d r%0d d%0d"},
						e.red, e.green, e.blue, e.alpha, e.col, e.row, e.done,
						got.red, got.green, got.blue, got.alpha, got.col, got.row,
						got.done);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] red_in = '0, green_in = '0, blue_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] red_out, green_out, blue_out, alpha_out;
	logic [OPOS_W-1:0] out_column, out_row;
	logic frame_done;

	box_scoreboard sb = new();
	int idle_cycles = 0;
	int pixels_sent = 0;
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;

	box_average_downscaler_core dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: stall pattern changes at random intervals
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_pixel('{red_out, green_out, blue_out, alpha_out,
					out_column, out_row, frame_done});
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				stall_left = $urandom_range(10, 60);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				default: out_ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// caller lowers cfg_we after its last write
	task automatic write_reg(cfg_reg_t idx, int unsigned v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v[CFG_W-1:0];
		@(posedge clk);
		sb.set_reg(idx, v);
	endtask

	task automatic wait_idle();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_sizes(int unsigned s_w, int unsigned s_h, int unsigned d_w,
			int unsigned d_h);
		in_valid <= 1'b0;
		wait_idle();
		write_reg(REG_SRC_WIDTH, s_w);
		write_reg(REG_SRC_HEIGHT, s_h);
		write_reg(REG_DST_WIDTH, d_w);
		write_reg(REG_DST_HEIGHT, d_h);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one word on the input channel, and at random a gap once a burst runs out
	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		in_valid <= 1'b1;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_pixel(r, g, b);
		pixels_sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_random(int n);
		repeat (n) send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	initial begin
		int unsigned s_w, s_h, d_w, d_h, frame;
		int burst_n;
		sb.init();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes: every pixel is its own box
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd170, 8'd85, 8'd1);
		// half-way rounding: two-pixel boxes
		set_sizes(2, 1, 1, 1);
		send_pixel(8'd0, 8'd255, 8'd254);
		send_pixel(8'd1, 8'd254, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd127);
		// uneven boxes over a 3x3 to 2x2 frame
		set_sizes(3, 3, 2, 2);
		send_random(9);
		// upscale request falls back to 1:1, zero sizes clamp to 1
		set_sizes(2, 2, 9'h1ff, 9'h1ff);
		send_random(4);
		set_sizes(0, 0, 0, 0);
		send_random(3);
		// largest sizes, including over-range values
		set_sizes(13'h1fff, 13'h1fff, 9'h1ff, 9'h1ff);
		send_random(150);
		set_sizes(MAX_SRC_WIDTH, 1, MAX_DST_WIDTH, 1);
		send_random(160);

		while (pixels_sent < TARGET_PIXELS) begin
			if ($urandom_range(0, 7) == 0) begin
				s_w = $urandom_range(1, 40);
				s_h = $urandom_range(1, 4);
			end else begin
				s_w = $urandom_range(1, 12);
				s_h = $urandom_range(1, 8);
			end
			d_w = $urandom_range(1, s_w);
			d_h = $urandom_range(1, s_h);
			set_sizes(s_w, s_h, d_w, d_h);
			frame = s_w * s_h;
			burst_n = frame * $urandom_range(1, 2) + $urandom_range(0, frame - 1);
			if (pixels_sent + burst_n > TARGET_PIXELS)
				burst_n = TARGET_PIXELS - pixels_sent;
			send_random(burst_n);
		end

		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> box_average_downscaler_core.f
+incdir+sv
sv/bxds_pkg.sv
sv/box_average_downscaler_core.sv
tb/box_average_downscaler_core_tb.sv
